[hdl/bsat_pkg.sv]
// Package for the binary summed-area table: shared types, character codes,
// the command passed from front to back, and the hex decode function.
// No dependencies.
package bsat_pkg;

  // Fixed field widths
  localparam int SUM_W      = 13;
  localparam int IDX_W      = 7;
  localparam int LANES      = 4;   // pixels per hex character, also table words lanes
  localparam int CORNERS    = 4;   // corners of a rectangle query

  localparam logic [IDX_W-1:0] SIZE_RESET = 7'd64;

  // Character codes
  localparam logic [7:0] CHAR_0   = 8'h30;
  localparam logic [7:0] CHAR_9   = 8'h39;
  localparam logic [7:0] CHAR_A   = 8'h41;
  localparam logic [7:0] CHAR_F   = 8'h46;
  localparam logic [7:0] HEX_TEN  = 8'd10;

  typedef logic [SUM_W-1:0] sum_t;
  typedef logic [IDX_W-1:0] idx_t;

  typedef enum logic [1:0] {
    OP_LOAD,
    OP_QUERY,
    OP_BAD
  } op_e;

  // One unit of work for the back end.
  // Load: row/col[0] = word written, row/col[1] = word above, en[1] = above exists,
  //       pre = running row count after each of the four pixels.
  // Query: four corners with enable (nonzero corner) and subtract flag.
  typedef struct packed {
    op_e                         op;
    logic [CORNERS-1:0][IDX_W-1:0] row;
    logic [CORNERS-1:0][IDX_W-1:0] col;
    logic [CORNERS-1:0]          en;
    logic [CORNERS-1:0]          sub;
    logic [LANES-1:0][IDX_W-1:0] pre;
  } cmd_t;

  // ASCII hex digit to value, anything else reads as zero
  function automatic logic [3:0] hex_value(input logic [7:0] ch);
    logic [7:0] d;
    if (ch >= CHAR_0 && ch <= CHAR_9) begin
      d = ch - CHAR_0;
    end else if (ch >= CHAR_A && ch <= CHAR_F) begin
      d = ch - CHAR_A + HEX_TEN;
    end else begin
      d = 8'd0;
    end
    return d[3:0];
  endfunction

endpackage

[hdl/bsat_in_if.sv]
// Input channel of the summed-area table: valid/ready plus the item fields.
// Depends on bsat_pkg.
interface bsat_in_if;
  logic              valid;
  logic              ready;
  logic              kind;
  logic [7:0]        hex_char;
  bsat_pkg::idx_t    row_top;
  bsat_pkg::idx_t    col_left;
  bsat_pkg::idx_t    row_bottom;
  bsat_pkg::idx_t    col_right;

  modport source (output valid, kind, hex_char, row_top, col_left, row_bottom, col_right,
                  input ready);
  modport sink   (input valid, kind, hex_char, row_top, col_left, row_bottom, col_right,
                  output ready);
endinterface

[hdl/bsat_out_if.sv]
// Result channel of the summed-area table: valid/ready plus box sum and flag.
// Depends on bsat_pkg.
interface bsat_out_if;
  logic            valid;
  logic            ready;
  bsat_pkg::sum_t  box_sum;
  logic            bad_query;

  modport source (output valid, box_sum, bad_query, input ready);
  modport sink   (input valid, box_sum, bad_query, output ready);
endinterface

[hdl/binary_summed_area_table.sv]
// Top level of the binary summed-area table: front end, command queue, back end.
// Depends on bsat_pkg, bsat_in_if, bsat_out_if, bsat_front, bsat_queue, bsat_back.
//
//   channel   direction  handshake      transaction
//   in_i      sink       valid/ready    one hex character or one rectangle query
//   out_o     source     valid/ready    box sum and bad-query flag, one per query
//   cfg       input      cfg_we_i       side length, restarts the load at row 1
//
// A load writes one word; once the queue is primed, the read of the word above
// overlaps the previous write. After issue a query reads its four corners one at
// a time through the table's single read port, then delivers its result; a bad
// query goes straight to its result. Reset clears control state only; table
// contents stay undefined until loaded. A query result waiting on a full result
// register stalls the back end; the two-entry queue then fills and drops in_i.ready.
module binary_summed_area_table #(
  parameter int MAX_SIDE = 64
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            cfg_we_i,
  input  bsat_pkg::idx_t  cfg_wdata_i,
  bsat_in_if.sink         in_i,
  bsat_out_if.source      out_o
);
  import bsat_pkg::*;

  cmd_t q_in, q_out;
  logic q_in_valid, q_in_ready, q_out_valid, q_out_ready;

  bsat_front #(
    .MAX_SIDE (MAX_SIDE)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_i        (in_i),
    .cmd_o       (q_in),
    .cmd_valid_o (q_in_valid),
    .cmd_ready_i (q_in_ready)
  );

  bsat_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_cmd_i   (q_in),
    .push_valid_i (q_in_valid),
    .push_ready_o (q_in_ready),
    .pop_cmd_o    (q_out),
    .pop_valid_o  (q_out_valid),
    .pop_ready_i  (q_out_ready)
  );

  bsat_back #(
    .MAX_SIDE (MAX_SIDE)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (q_out),
    .cmd_valid_i (q_out_valid),
    .cmd_ready_o (q_out_ready),
    .out_o       (out_o)
  );

  // A flagged query always reports a zero sum
  a_bad_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.bad_query |-> out_o.box_sum == '0)
    else $error("bad query with nonzero sum");

  // Loads queued for the back end stay inside the table
  a_load_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_in_valid && q_in.op == OP_LOAD |->
      int'(q_in.row[0]) < MAX_SIDE && int'(q_in.col[0]) < MAX_SIDE)
    else $error("load command outside table");

  // Accepted queries address their main corner inside the table
  a_query_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_in_valid && q_in.op == OP_QUERY |->
      int'(q_in.row[0]) < MAX_SIDE && int'(q_in.col[0]) < MAX_SIDE)
    else $error("query corner outside table");

endmodule

[hdl/bsat_front.sv]
// Front end: takes input transactions, tracks the load position and running
// row count, checks queries and builds commands. Depends on bsat_pkg, bsat_in_if.
module bsat_front #(
  parameter int MAX_SIDE = 64
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  bsat_pkg::idx_t    cfg_wdata_i,
  bsat_in_if.sink           in_i,
  output bsat_pkg::cmd_t    cmd_o,
  output logic              cmd_valid_o,
  input  logic              cmd_ready_i
);
  import bsat_pkg::*;

  idx_t       size_q;
  idx_t       row_q;       // 1-based row being loaded
  logic [4:0] dc_q;        // next hex digit within the row
  idx_t       rs_q;        // set pixels so far in this row

  idx_t       capped, side;
  logic [4:0] digits, dc_eff, dc_next;
  logic [3:0] hv;
  logic       load_ok, bad, accept;
  idx_t       run;
  logic [LANES-1:0][IDX_W-1:0] pre;
  idx_t       r1, c1, r2, c2;

  // Side in use: capped, rounded down to a multiple of four, never zero
  always_comb begin
    capped = (int'(size_q) > MAX_SIDE) ? IDX_W'(MAX_SIDE) : size_q;
    side   = {capped[IDX_W-1:2], 2'b00};
    if (side == '0) begin
      side = 7'd4;
    end
    digits = side[IDX_W-1:2];
  end

  // Load: decode pixels and running counts
  always_comb begin
    hv      = hex_value(in_i.hex_char);
    load_ok = (row_q != '0) && (row_q <= side);
    dc_eff  = (dc_q >= digits) ? 5'd0 : dc_q;
    dc_next = dc_eff + 5'd1;
    run     = rs_q;
    for (int k = 0; k < LANES; k++) begin
      run    = run + IDX_W'(hv[LANES-1-k]);
      pre[k] = run;
    end
  end

  // Query: range check
  assign r1  = in_i.row_top;
  assign c1  = in_i.col_left;
  assign r2  = in_i.row_bottom;
  assign c2  = in_i.col_right;
  assign bad = (r1 == '0) || (c1 == '0) || (r2 > side) || (c2 > side) ||
               (r1 > r2) || (c1 > c2);

  // Command build
  always_comb begin
    cmd_o     = '0;
    cmd_o.pre = pre;
    if (in_i.kind) begin
      cmd_o.op     = bad ? OP_BAD : OP_QUERY;
      cmd_o.row[0] = r2 - 7'd1;  cmd_o.col[0] = c2 - 7'd1;
      cmd_o.en[0]  = 1'b1;       cmd_o.sub[0] = 1'b0;
      cmd_o.row[1] = r2 - 7'd1;  cmd_o.col[1] = c1 - 7'd2;
      cmd_o.en[1]  = c1 > 7'd1;  cmd_o.sub[1] = 1'b1;
      cmd_o.row[2] = r1 - 7'd2;  cmd_o.col[2] = c2 - 7'd1;
      cmd_o.en[2]  = r1 > 7'd1;  cmd_o.sub[2] = 1'b1;
      cmd_o.row[3] = r1 - 7'd2;  cmd_o.col[3] = c1 - 7'd2;
      cmd_o.en[3]  = (r1 > 7'd1) && (c1 > 7'd1);
      cmd_o.sub[3] = 1'b0;
    end else begin
      cmd_o.op     = OP_LOAD;
      cmd_o.row[0] = row_q - 7'd1;
      cmd_o.col[0] = {dc_eff, 2'b00};
      cmd_o.row[1] = row_q - 7'd2;
      cmd_o.col[1] = {dc_eff, 2'b00};
      cmd_o.en[1]  = row_q > 7'd1;
    end
  end

  // Ignored loads (image full) are taken without a command
  assign cmd_valid_o = in_i.valid && (in_i.kind || load_ok);
  assign in_i.ready  = cmd_ready_i;
  assign accept      = in_i.valid && in_i.ready;

  // Load position and size register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_q <= SIZE_RESET;
      row_q  <= 7'd1;
      dc_q   <= '0;
      rs_q   <= '0;
    end else if (cfg_we_i) begin
      size_q <= cfg_wdata_i;
      row_q  <= 7'd1;
      dc_q   <= '0;
      rs_q   <= '0;
    end else if (accept && !in_i.kind && load_ok) begin
      if (dc_next >= digits) begin
        dc_q  <= '0;
        rs_q  <= '0;
        row_q <= row_q + 7'd1;
      end else begin
        dc_q  <= dc_next;
        rs_q  <= pre[LANES-1];
      end
    end
  end

endmodule

[hdl/bsat_queue.sv]
// Two-entry command queue between front and back ends.
// Depends on bsat_pkg.
module bsat_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  bsat_pkg::cmd_t  push_cmd_i,
  input  logic            push_valid_i,
  output logic            push_ready_o,
  output bsat_pkg::cmd_t  pop_cmd_o,
  output logic            pop_valid_o,
  input  logic            pop_ready_i
);
  import bsat_pkg::*;

  cmd_t       slot_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] count_q;
  logic       push, pop;

  assign push_ready_o = (count_q != 2'd2);
  assign pop_valid_o  = (count_q != 2'd0);
  assign pop_cmd_o    = slot_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  // Storage
  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wr_ptr_q] <= push_cmd_i;
    end
  end

  // Pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (pop) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      if (push && !pop) begin
        count_q <= count_q + 2'd1;
      end else if (pop && !push) begin
        count_q <= count_q - 2'd1;
      end
    end
  end

endmodule

[hdl/bsat_back.sv]
// Back end: owns the table memory (four entries per word), writes loaded
// words and walks the four corners of a query. Depends on bsat_pkg, bsat_out_if.
module bsat_back #(
  parameter int MAX_SIDE = 64
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  bsat_pkg::cmd_t  cmd_i,
  input  logic            cmd_valid_i,
  output logic            cmd_ready_o,
  bsat_out_if.source      out_o
);
  import bsat_pkg::*;

  localparam int RW    = $clog2(MAX_SIDE);
  localparam int DW    = (RW > 2) ? RW - 2 : 1;
  localparam int AW    = RW + DW;
  localparam int DEPTH = 1 << AW;

  typedef enum logic [1:0] {
    S_IDLE,
    S_LOAD,
    S_QUERY,
    S_DONE
  } state_e;

  typedef logic [LANES-1:0][SUM_W-1:0] word_t;

  function automatic logic [AW-1:0] word_addr(input idx_t row, input idx_t col);
    return {RW'(row), DW'(col[IDX_W-1:2])};
  endfunction

  word_t      mem [DEPTH];
  word_t      rd_q;
  state_e     state_q;
  cmd_t       cmd_q;
  logic [2:0] cnt_q;
  logic       pend_q, ren_q, rsub_q, bad_q;
  logic [1:0] lane_q;
  sum_t       acc_q;
  logic       out_valid_q, out_bad_q;
  sum_t       out_sum_q;

  logic            pop, wr_en;
  logic [AW-1:0]   wr_addr, rd_addr;
  word_t           wr_data;
  idx_t            rd_row, rd_col;
  sum_t            term;

  assign pop         = cmd_valid_i && ((state_q == S_IDLE) || (state_q == S_LOAD));
  assign cmd_ready_o = pop;

  // Load write: above entry plus running row count, lane by lane
  assign wr_en   = (state_q == S_LOAD);
  assign wr_addr = word_addr(cmd_q.row[0], cmd_q.col[0]);
  always_comb begin
    for (int k = 0; k < LANES; k++) begin
      wr_data[k] = cmd_q.en[1] ? rd_q[k] + SUM_W'(cmd_q.pre[k]) : SUM_W'(cmd_q.pre[k]);
    end
  end

  // Read address: word above for a new load, first corner for a new query,
  // else the next corner of the current query
  always_comb begin
    if (pop) begin
      if (cmd_i.op == OP_LOAD) begin
        rd_row = cmd_i.row[1];
        rd_col = cmd_i.col[1];
      end else begin
        rd_row = cmd_i.row[0];
        rd_col = cmd_i.col[0];
      end
    end else begin
      rd_row = cmd_q.row[cnt_q[1:0]];
      rd_col = cmd_q.col[cnt_q[1:0]];
    end
    rd_addr = word_addr(rd_row, rd_col);
  end

  assign term = ren_q ? rd_q[lane_q] : '0;

  // Table memory with write-to-read bypass on the same word
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (wr_en && (wr_addr == rd_addr)) begin
      rd_q <= wr_data;
    end else begin
      rd_q <= mem[rd_addr];
    end
  end

  // Sequencer and result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cmd_q       <= '0;
      cnt_q       <= '0;
      pend_q      <= 1'b0;
      ren_q       <= 1'b0;
      rsub_q      <= 1'b0;
      lane_q      <= '0;
      bad_q       <= 1'b0;
      acc_q       <= '0;
      out_valid_q <= 1'b0;
      out_bad_q   <= 1'b0;
      out_sum_q   <= '0;
    end else begin
      // Result taken; in S_DONE the refill below decides the valid bit
      if (out_valid_q && out_o.ready && (state_q != S_DONE)) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE, S_LOAD: begin
          if (pop) begin
            cmd_q  <= cmd_i;
            lane_q <= cmd_i.col[0][1:0];
            ren_q  <= cmd_i.en[0];
            rsub_q <= cmd_i.sub[0];
            pend_q <= 1'b1;
            cnt_q  <= 3'd1;
            acc_q  <= '0;
            bad_q  <= (cmd_i.op == OP_BAD);
            case (cmd_i.op)
              OP_LOAD:  state_q <= S_LOAD;
              OP_QUERY: state_q <= S_QUERY;
              OP_BAD:   state_q <= S_DONE;
              default:  state_q <= S_IDLE;
            endcase
          end else begin
            state_q <= S_IDLE;
          end
        end
        S_QUERY: begin
          if (pend_q) begin
            acc_q <= rsub_q ? acc_q - term : acc_q + term;
          end
          if (cnt_q == 3'(CORNERS)) begin
            pend_q  <= 1'b0;
            state_q <= S_DONE;
          end else begin
            lane_q <= cmd_q.col[cnt_q[1:0]][1:0];
            ren_q  <= cmd_q.en[cnt_q[1:0]];
            rsub_q <= cmd_q.sub[cnt_q[1:0]];
            pend_q <= 1'b1;
            cnt_q  <= cnt_q + 3'd1;
          end
        end
        S_DONE: begin
          if (!out_valid_q || out_o.ready) begin
            out_valid_q <= 1'b1;
            out_sum_q   <= acc_q;
            out_bad_q   <= bad_q;
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign out_o.valid     = out_valid_q;
  assign out_o.box_sum   = out_sum_q;
  assign out_o.bad_query = out_bad_q;

endmodule

[tb/sv/tb.sv]
// Testbench for binary_summed_area_table: drives hex-character loads and rectangle queries,
// predicts every box sum in a scoreboard class and checks each result transaction.
// Depends on bsat_pkg, bsat_in_if, bsat_out_if and the binary_summed_area_table RTL.
`timescale 1ns / 100ps

module tb;
  import bsat_pkg::*;

  localparam int          MAX_SIDE      = 64;
  localparam int          ITEM_TARGET   = 1350;
  localparam int          SETTLE_CYCLES = 24;
  localparam int          CYCLE_LIMIT   = 400000;
  localparam logic        KIND_LOAD     = 1'b0;
  localparam logic        KIND_QUERY    = 1'b1;
  localparam int          PLAN_LEN      = 14;
  localparam idx_t        SIDE_PLAN [PLAN_LEN] =
    '{7'd4, 7'd0, 7'd127, 7'd8, 7'd3, 7'd64, 7'd5, 7'd16, 7'd65, 7'd12, 7'd1, 7'd100, 7'd7,
      7'd2};

  typedef struct {
    logic       kind;
    logic [7:0] hex_char;
    idx_t       row_top;
    idx_t       col_left;
    idx_t       row_bottom;
    idx_t       col_right;
  } sat_item_t;

  typedef struct {
    sum_t box_sum;
    logic bad_query;
  } box_result_t;

  typedef enum int {
    SHAPE_WHOLE,
    SHAPE_PIXEL,
    SHAPE_TOP_ZERO,
    SHAPE_LEFT_ZERO,
    SHAPE_BOTTOM_OUT,
    SHAPE_RIGHT_OUT,
    SHAPE_ROWS_SWAPPED,
    SHAPE_COLS_SWAPPED,
    SHAPE_ANY,
    SHAPE_SPAN
  } query_shape_e;

  // Shadow summed-area table plus the queue of box sums still owed by the block
  class box_scoreboard;
    sum_t        sat_word [MAX_SIDE*MAX_SIDE];
    bit          loaded   [MAX_SIDE*MAX_SIDE];
    idx_t        side_reg;
    int unsigned load_row, load_digit, row_count;
    box_result_t owed_sums [$];
    int unsigned failures, reported;

    function new();
      side_reg  = SIZE_RESET;
      failures  = 0;
      reported  = 0;
      restart_load();
    endfunction

    function void restart_load();
      load_row   = 1;
      load_digit = 0;
      row_count  = 0;
    endfunction

    function void write_size(input idx_t value);
      side_reg = value;
      restart_load();
    endfunction

    // Side in use: capped, rounded down to a multiple of four, never zero
    function int unsigned side();
      int unsigned s;
      s = (side_reg > MAX_SIDE) ? MAX_SIDE : side_reg;
      s = s - (s % 4);
      return (s == 0) ? 4 : s;
    endfunction

    function bit image_full();
      return load_row > side();
    endfunction

    function int unsigned pending();
      return owed_sums.size();
    endfunction

    function logic [3:0] nibble_of(input logic [7:0] ch);
      if (ch >= CHAR_0 && ch <= CHAR_9) return 4'(ch - CHAR_0);
      if (ch >= CHAR_A && ch <= CHAR_F) return 4'(ch - CHAR_A + HEX_TEN);
      return 4'd0;
    endfunction

    function sum_t entry(input int unsigned r, input int unsigned c);
      if (r == 0 || c == 0) return '0;
      return sat_word[(r-1)*MAX_SIDE + c - 1];
    endfunction

    function bit readable(input int unsigned r, input int unsigned c);
      return r == 0 || c == 0 || loaded[(r-1)*MAX_SIDE + c - 1];
    endfunction

    function bit is_bad(input sat_item_t it);
      int unsigned n;
      n = side();
      return it.row_top < 1 || it.col_left < 1 || it.row_bottom > n || it.col_right > n ||
             it.row_top > it.row_bottom || it.col_left > it.col_right;
    endfunction

    // A query must never touch a table entry that was not written since power-up
    function bit box_readable(input sat_item_t it);
      if (is_bad(it)) return 1'b1;
      return readable(it.row_bottom, it.col_right) && readable(it.row_bottom, it.col_left - 1) &&
             readable(it.row_top - 1, it.col_right) &&
             readable(it.row_top - 1, it.col_left - 1);
    endfunction

    // Four pixels of one character into the current row
    function void store_char(input logic [7:0] ch);
      int unsigned n, digits, col, idx;
      logic [3:0]  bits;
      sum_t        above;
      n      = side();
      digits = n / LANES;
      bits   = nibble_of(ch);
      if (load_row < 1 || load_row > n) return;
      if (load_digit >= digits) load_digit = 0;
      for (int k = 0; k < LANES; k++) begin
        col       = load_digit*LANES + k;
        above     = (load_row > 1) ? sat_word[(load_row-2)*MAX_SIDE + col] : '0;
        row_count = row_count + bits[LANES-1-k];
        idx       = (load_row-1)*MAX_SIDE + col;
        sat_word[idx] = above + sum_t'(row_count);
        loaded[idx]   = 1'b1;
      end
      load_digit++;
      if (load_digit >= digits) begin
        load_digit = 0;
        row_count  = 0;
        load_row++;
      end
    endfunction

    // Called for every accepted input transaction
    function void accept_item(input sat_item_t it);
      box_result_t want;
      if (it.kind == KIND_LOAD) begin
        store_char(it.hex_char);
        return;
      end
      if (is_bad(it)) begin
        want.box_sum   = '0;
        want.bad_query = 1'b1;
      end else begin
        want.box_sum = entry(it.row_bottom, it.col_right) -
                       entry(it.row_bottom, it.col_left - 1) -
                       entry(it.row_top - 1, it.col_right) +
                       entry(it.row_top - 1, it.col_left - 1);
        want.bad_query = 1'b0;
      end
      owed_sums = {owed_sums, want};
    endfunction

    // Called for every accepted result transaction
    function void check_box(input sum_t got_sum, input logic got_bad);
      box_result_t want;
      if (owed_sums.size() == 0) begin
        failures++;
        if (reported < 10) begin
          reported++;
          $display("%0t: unexpected result box_sum=%0d bad_query=%0b", $time, got_sum, got_bad);
        end
        return;
      end
      want = owed_sums.pop_front();
      if (got_sum !== want.box_sum || got_bad !== want.bad_query) begin
        failures++;
        if (reported < 10) begin
          reported++;
          $display("%0t: mismatch box_sum exp %0d got %0d, bad_query exp %0b got %0b",
                   $time, want.box_sum, got_sum, want.bad_query, got_bad);
        end
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni;
  logic cfg_we;
  idx_t cfg_wdata;
  int   send_mode, sink_mode;
  int   items_sent;
  int   cycle_count;

  box_scoreboard sb = new();

  bsat_in_if  in_bus ();
  bsat_out_if out_bus ();

  binary_summed_area_table #(
    .MAX_SIDE (MAX_SIDE)
  ) dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .in_i        (in_bus),
    .out_o       (out_bus)
  );

  // 10 ns clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  initial begin
    rst_ni = 1'b0;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
  end

  // Run limit
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("** binary_summed_area_table: FAILED **");
      $finish;
    end
  end

  // Idle length: mode 0 never idles, 1 idles lightly, 2 heavily; long gaps are rare
  function automatic int pick_gap(input int mode);
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (mode == 0) return 0;
    if (mode == 1) begin
      if (roll < 85) return 0;
      if (roll < 98) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
    end
    if (roll < 50) return 0;
    if (roll < 90) return $urandom_range(1, 4);
    return $urandom_range(10, 40);
  endfunction

  // Mostly uppercase hex, some lowercase (loads as zero) and arbitrary bytes
  function automatic logic [7:0] pick_char();
    int unsigned roll, nib;
    roll = $urandom_range(0, 99);
    nib  = $urandom_range(0, 15);
    if (roll < 6) return 8'($urandom_range(0, 255));
    if (roll < 12) return "a" + 8'($urandom_range(0, 5));
    return (nib < 10) ? CHAR_0 + 8'(nib) : CHAR_A + 8'(nib) - HEX_TEN;
  endfunction

  // Result side: random back-pressure, check at the rising edge
  initial begin
    int stall;
    stall         = 0;
    out_bus.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (stall > 0) begin
        out_bus.ready = 1'b0;
        stall--;
      end else begin
        out_bus.ready = 1'b1;
        stall = pick_gap(sink_mode);
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_bus.valid === 1'b1 && out_bus.ready === 1'b1) begin
      sb.check_box(out_bus.box_sum, out_bus.bad_query);
    end
  end

  // One input transaction, with an optional idle gap before it
  task automatic send_item(input sat_item_t it);
    int gap;
    gap = pick_gap(send_mode);
    @(negedge clk_i);
    if (gap > 0) begin
      in_bus.valid = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_bus.kind       = it.kind;
    in_bus.hex_char   = it.hex_char;
    in_bus.row_top    = it.row_top;
    in_bus.col_left   = it.col_left;
    in_bus.row_bottom = it.row_bottom;
    in_bus.col_right  = it.col_right;
    in_bus.valid      = 1'b1;
    do @(posedge clk_i); while (in_bus.ready !== 1'b1);
    sb.accept_item(it);
  endtask

  task automatic load_char(input logic [7:0] ch);
    sat_item_t it;
    it.kind       = KIND_LOAD;
    it.hex_char   = ch;
    it.row_top    = idx_t'($urandom_range(0, 127));
    it.col_left   = idx_t'($urandom_range(0, 127));
    it.row_bottom = idx_t'($urandom_range(0, 127));
    it.col_right  = idx_t'($urandom_range(0, 127));
    if (!sb.image_full()) items_sent++;
    send_item(it);
  endtask

  task automatic ask_box(input int r1, input int c1, input int r2, input int c2);
    sat_item_t it;
    it.kind       = KIND_QUERY;
    it.hex_char   = 8'($urandom_range(0, 255));
    it.row_top    = idx_t'(r1);
    it.col_left   = idx_t'(c1);
    it.row_bottom = idx_t'(r2);
    it.col_right  = idx_t'(c2);
    items_sent++;
    send_item(it);
  endtask

  // Random rectangle, good or bad, that only reads entries already written
  task automatic random_query();
    int           n, r1, c1, r2, c2;
    query_shape_e shape;
    sat_item_t    probe;
    n = sb.side();
    for (int t = 0; t < 20; t++) begin
      shape = query_shape_e'($urandom_range(0, SHAPE_SPAN + 4));
      r1 = $urandom_range(1, n);
      c1 = $urandom_range(1, n);
      r2 = $urandom_range(r1, n);
      c2 = $urandom_range(c1, n);
      case (shape)
        SHAPE_WHOLE: begin
          r1 = 1; c1 = 1; r2 = n; c2 = n;
        end
        SHAPE_PIXEL: begin
          r2 = r1; c2 = c1;
        end
        SHAPE_TOP_ZERO:   r1 = 0;
        SHAPE_LEFT_ZERO:  c1 = 0;
        SHAPE_BOTTOM_OUT: r2 = $urandom_range(n + 1, 127);
        SHAPE_RIGHT_OUT:  c2 = $urandom_range(n + 1, 127);
        SHAPE_ROWS_SWAPPED: begin
          r1 = $urandom_range(2, 127);
          r2 = $urandom_range(0, r1 - 1);
        end
        SHAPE_COLS_SWAPPED: begin
          c1 = $urandom_range(2, 127);
          c2 = $urandom_range(0, c1 - 1);
        end
        SHAPE_ANY: begin
          r1 = $urandom_range(0, 127); c1 = $urandom_range(0, 127);
          r2 = $urandom_range(0, 127); c2 = $urandom_range(0, 127);
        end
        default: ;
      endcase
      probe.row_top    = idx_t'(r1);
      probe.col_left   = idx_t'(c1);
      probe.row_bottom = idx_t'(r2);
      probe.col_right  = idx_t'(c2);
      if (sb.box_readable(probe)) break;
    end
    if (!sb.box_readable(probe)) r1 = 0;
    ask_box(r1, c1, r2, c2);
  endtask

  // Hold the sender until every owed sum is back, then let queued loads finish
  task automatic settle_results();
    @(negedge clk_i);
    in_bus.valid = 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_side(input idx_t value);
    settle_results();
    @(negedge clk_i);
    cfg_we    = 1'b1;
    cfg_wdata = value;
    @(negedge clk_i);
    cfg_we = 1'b0;
    sb.write_size(value);
  endtask

  // Stimulus
  initial begin
    logic [7:0] row_one [16];
    int         phase, n, rows;
    row_one = '{CHAR_0, CHAR_9, CHAR_A, CHAR_F, "a", "f", "G", "/", ":", "@", 8'hFF, 8'h00,
                "5", "C", "7", "3"};
    in_bus.valid      = 1'b0;
    in_bus.kind       = KIND_LOAD;
    in_bus.hex_char   = '0;
    in_bus.row_top    = '0;
    in_bus.col_left   = '0;
    in_bus.row_bottom = '0;
    in_bus.col_right  = '0;
    cfg_we            = 1'b0;
    cfg_wdata         = '0;
    send_mode         = 0;
    sink_mode         = 0;
    items_sent        = 0;
    cycle_count       = 0;
    @(posedge rst_ni);

    // Directed: bad corners before any load, then row one at the reset side of 64
    ask_box(0, 1, 1, 1);
    ask_box(1, 0, 1, 1);
    ask_box(1, 1, 127, 65);
    ask_box(5, 1, 4, 1);
    ask_box(1, 9, 1, 8);
    foreach (row_one[i]) load_char(row_one[i]);
    ask_box(1, 1, 1, 64);
    ask_box(1, 64, 1, 64);
    ask_box(1, 1, 1, 1);

    // Random phases: new side, load (sometimes abandoned), queries
    phase = 0;
    while (items_sent < ITEM_TARGET) begin
      if (phase < PLAN_LEN) write_side(SIDE_PLAN[phase]);
      else if ($urandom_range(0, 4) != 0) write_side(idx_t'($urandom_range(0, 19)));
      else write_side(idx_t'($urandom_range(0, 127)));
      n         = sb.side();
      send_mode = $urandom_range(0, 2);
      sink_mode = $urandom_range(0, 2);
      rows      = (n <= 16) ? n : $urandom_range(1, 3);
      if (n <= 16 && $urandom_range(0, 5) == 0) rows = $urandom_range(0, n - 1);
      for (int i = 0; i < rows * n / LANES; i++) begin
        load_char(pick_char());
        if ($urandom_range(0, 19) == 0) random_query();
      end
      if (sb.image_full()) begin
        repeat ($urandom_range(0, 3)) load_char(pick_char());
      end
      repeat ($urandom_range(2, 7)) random_query();
      if (phase % 4 == 1) settle_results();
      repeat ($urandom_range(2, 7)) random_query();
      phase++;
    end

    settle_results();
    if (sb.failures == 0) begin
      $display("** binary_summed_area_table: PASSED **");
    end else begin
      $display("** binary_summed_area_table: FAILED **");
    end
    $finish;
  end

endmodule

[files.f]
hdl/bsat_pkg.sv
hdl/bsat_in_if.sv
hdl/bsat_out_if.sv
hdl/bsat_front.sv
hdl/bsat_queue.sv
hdl/bsat_back.sv
hdl/binary_summed_area_table.sv
tb/sv/tb.sv
